### hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");
`endif

### hdl/rbie_pkg.sv
// Package: widths, opcodes and codes for the execute core.
`timescale 1ns / 1ps
package rbie_pkg;
  localparam int unsigned Xlen     = 64;
  localparam int unsigned RegCount = 32;
  localparam int unsigned RegAw    = $clog2(RegCount);
  localparam int unsigned ShW      = $clog2(Xlen);

  localparam logic [6:0] OpReg    = 7'h33;
  localparam logic [6:0] OpImm    = 7'h13;
  localparam logic [6:0] OpLui    = 7'h37;
  localparam logic [6:0] OpAuipc  = 7'h17;
  localparam logic [6:0] OpBranch = 7'h63;
  localparam logic [6:0] OpJal    = 7'h6F;
  localparam logic [6:0] OpJalr   = 7'h67;
  localparam logic [6:0] OpLoad   = 7'h03;
  localparam logic [6:0] OpStore  = 7'h23;
  localparam logic [6:0] OpSystem = 7'h73;

  localparam logic [31:0] InsEcall  = 32'h0000_0073;
  localparam logic [31:0] InsEbreak = 32'h0010_0073;

  localparam logic [1:0] StDone    = 2'd0;
  localparam logic [1:0] StIllegal = 2'd1;
  localparam logic [1:0] StRefused = 2'd2;

  localparam logic [1:0] MrNone  = 2'd0;
  localparam logic [1:0] MrLoad  = 2'd1;
  localparam logic [1:0] MrStore = 2'd2;

  localparam logic [2:0] TcNone  = 3'd0;
  localparam logic [2:0] TcBreak = 3'd1;
  localparam logic [2:0] TcEcU   = 3'd2;
  localparam logic [2:0] TcEcS   = 3'd3;
  localparam logic [2:0] TcEcM   = 3'd4;

  localparam logic CfgPriv  = 1'b0;
  localparam logic CfgStart = 1'b1;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] next_pc;
    logic [1:0]  mem_request;
    logic [63:0] mem_address;
    logic [1:0]  mem_size;
    logic [31:0] mem_write_data;
    logic [2:0]  trap_cause;
    logic        wb_valid;
    logic [4:0]  wb_index;
    logic [63:0] wb_value;
  } result_t;

  // Signed less-than on XLEN bits.
  function automatic logic slt_f(input logic [Xlen-1:0] a, input logic [Xlen-1:0] b);
    slt_f = $signed(a) < $signed(b);
  endfunction
endpackage

### hdl/rbie_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module rbie_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### hdl/rbie_regfile.sv
// Register file: two RAM read ports, valid bits for reset, write forwarding.
`timescale 1ns / 1ps
module rbie_regfile import rbie_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [RegAw-1:0] ra_i,
  input  logic [RegAw-1:0] rb_i,
  input  logic             we_i,
  input  logic [RegAw-1:0] wa_i,
  input  logic [Xlen-1:0]  wd_i,
  output logic [Xlen-1:0]  a_o,
  output logic [Xlen-1:0]  b_o
);
  logic [Xlen-1:0]     ram_a, ram_b, fwd_d_q;
  logic [RegCount-1:0] vld_q;
  logic [RegAw-1:0]    ra_q, rb_q;
  logic                fa_q, fb_q;

  rbie_ram #(.Width(Xlen), .Depth(RegCount)) u_ram_a (
    .clk_i, .we_i, .waddr_i(wa_i), .wdata_i(wd_i), .raddr_i(ra_i), .rdata_o(ram_a));
  rbie_ram #(.Width(Xlen), .Depth(RegCount)) u_ram_b (
    .clk_i, .we_i, .waddr_i(wa_i), .wdata_i(wd_i), .raddr_i(rb_i), .rdata_o(ram_b));

  // Valid bits make never-written entries read zero; x0 is never written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (we_i && wa_i != '0) begin
      vld_q[wa_i] <= 1'b1;
    end
  end

  // Forward a same-cycle write into the registered read.
  always_ff @(posedge clk_i) begin
    ra_q    <= ra_i;
    rb_q    <= rb_i;
    fa_q    <= we_i && wa_i == ra_i;
    fb_q    <= we_i && wa_i == rb_i;
    fwd_d_q <= wd_i;
  end

  logic va, vb;
  assign va  = vld_q[ra_q] || fa_q;
  assign vb  = vld_q[rb_q] || fb_q;
  assign a_o = (ra_q == '0 || !va) ? '0 : (fa_q ? fwd_d_q : ram_a);
  assign b_o = (rb_q == '0 || !vb) ? '0 : (fb_q ? fwd_d_q : ram_b);
endmodule

### hdl/rbie_exec.sv
// Execute logic: decodes one instruction or load return and forms its result.
`timescale 1ns / 1ps
module rbie_exec import rbie_pkg::*; (
  input  logic            cmd_i,
  input  logic [31:0]     ins_i,
  input  logic [31:0]     ld_data_i,
  input  logic            ld_ok_i,
  input  logic [Xlen-1:0] a_i,
  input  logic [Xlen-1:0] b_i,
  input  logic [63:0]     pc_i,
  input  logic [1:0]      priv_i,
  input  logic            pend_i,
  input  logic [4:0]      pdest_i,
  input  logic [2:0]      pkind_i,
  output result_t         res_o,
  output logic            set_pend_o,
  output logic            clr_pend_o
);
  logic [6:0]  op;
  logic [4:0]  rd;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [63:0] imm_i, imm_s, imm_b, imm_j, imm_u, npc, pc4, alu_b, alu_r;
  logic        ill, alt, tk;
  logic [5:0]  sh;

  assign op = ins_i[6:0];
  assign rd = ins_i[11:7];
  assign f3 = ins_i[14:12];
  assign f7 = ins_i[31:25];
  assign imm_i = {{52{ins_i[31]}}, ins_i[31:20]};
  assign imm_s = {{52{ins_i[31]}}, ins_i[31:25], ins_i[11:7]};
  assign imm_b = {{51{ins_i[31]}}, ins_i[31], ins_i[7], ins_i[30:25], ins_i[11:8], 1'b0};
  assign imm_j = {{43{ins_i[31]}}, ins_i[31], ins_i[19:12], ins_i[20], ins_i[30:21], 1'b0};
  assign imm_u = {{32{ins_i[31]}}, ins_i[31:12], 12'h000};
  assign pc4   = pc_i + 64'd4;

  // Shared ALU for register and immediate forms.
  always_comb begin
    alt   = (op == OpReg) ? f7[5] : (f3 == 3'd5 && ins_i[30]);
    alu_b = (op == OpReg) ? b_i : imm_i;
    sh    = alu_b[ShW-1:0];
    case (f3)
      3'd0:    alu_r = (alt && op == OpReg) ? a_i - alu_b : a_i + alu_b;
      3'd1:    alu_r = a_i << sh;
      3'd2:    alu_r = {63'd0, slt_f(a_i, alu_b)};
      3'd3:    alu_r = {63'd0, a_i < alu_b};
      3'd4:    alu_r = a_i ^ alu_b;
      3'd5:    alu_r = alt ? 64'($signed(a_i) >>> sh) : a_i >> sh;
      3'd6:    alu_r = a_i | alu_b;
      default: alu_r = a_i & alu_b;
    endcase
  end

  always_comb begin
    case (f3)
      3'd0:    tk = a_i == b_i;
      3'd1:    tk = a_i != b_i;
      3'd4:    tk = slt_f(a_i, b_i);
      3'd5:    tk = !slt_f(a_i, b_i);
      3'd6:    tk = a_i < b_i;
      default: tk = a_i >= b_i;
    endcase
  end

  always_comb begin
    res_o      = '0;
    set_pend_o = 1'b0;
    clr_pend_o = 1'b0;
    ill        = 1'b0;
    npc        = pc4;
    res_o.next_pc = pc_i;
    if (cmd_i) begin
      // Load return.
      if (!pend_i) begin
        res_o.status = StRefused;
      end else begin
        clr_pend_o = 1'b1;
        if (ld_ok_i && pdest_i != '0) begin
          res_o.wb_valid = 1'b1;
          res_o.wb_index = pdest_i;
          case (pkind_i)
            3'd0:    res_o.wb_value = {{56{ld_data_i[7]}}, ld_data_i[7:0]};
            3'd1:    res_o.wb_value = {{48{ld_data_i[15]}}, ld_data_i[15:0]};
            3'd2:    res_o.wb_value = {{32{ld_data_i[31]}}, ld_data_i};
            3'd4:    res_o.wb_value = {56'd0, ld_data_i[7:0]};
            default: res_o.wb_value = {48'd0, ld_data_i[15:0]};
          endcase
        end
      end
    end else if (pend_i) begin
      res_o.status = StRefused;
    end else begin
      case (op)
        OpReg: begin
          if (!(f7 == 7'h00 || (f7 == 7'h20 && (f3 == 3'd0 || f3 == 3'd5)))) ill = 1'b1;
          res_o.wb_value = alu_r;
          res_o.wb_valid = 1'b1;
        end
        OpImm: begin
          if ((f3 == 3'd1 || f3 == 3'd5) &&
              !(ins_i[31:26] == 6'h00 || (ins_i[31:26] == 6'h10 && f3 == 3'd5))) ill = 1'b1;
          res_o.wb_value = alu_r;
          res_o.wb_valid = 1'b1;
        end
        OpLui: begin
          res_o.wb_value = imm_u;
          res_o.wb_valid = 1'b1;
        end
        OpAuipc: begin
          res_o.wb_value = pc_i + imm_u;
          res_o.wb_valid = 1'b1;
        end
        OpBranch: begin
          if (f3 == 3'd2 || f3 == 3'd3) ill = 1'b1;
          if (tk) npc = pc_i + imm_b;
        end
        OpJal: begin
          res_o.wb_value = pc4;
          res_o.wb_valid = 1'b1;
          npc = pc_i + imm_j;
        end
        OpJalr: begin
          if (f3 != 3'd0) ill = 1'b1;
          res_o.wb_value = pc4;
          res_o.wb_valid = 1'b1;
          npc = (a_i + imm_i) & ~64'd1;
        end
        OpLoad: begin
          if (f3 == 3'd3 || f3 > 3'd5) ill = 1'b1;
          res_o.mem_request = MrLoad;
          res_o.mem_address = a_i + imm_i;
          res_o.mem_size    = {1'b0, f3[0]} | {f3[1], 1'b0};
          set_pend_o        = 1'b1;
        end
        OpStore: begin
          if (f3 > 3'd2) ill = 1'b1;
          res_o.mem_request = MrStore;
          res_o.mem_address = a_i + imm_s;
          res_o.mem_size    = f3[1:0];
          case (f3[1:0])
            2'd0:    res_o.mem_write_data = {24'd0, b_i[7:0]};
            2'd1:    res_o.mem_write_data = {16'd0, b_i[15:0]};
            default: res_o.mem_write_data = b_i[31:0];
          endcase
        end
        OpSystem: begin
          npc = pc_i;
          if (ins_i == InsEcall) begin
            case (priv_i)
              2'd0:    res_o.trap_cause = TcEcU;
              2'd1:    res_o.trap_cause = TcEcS;
              2'd3:    res_o.trap_cause = TcEcM;
              default: res_o.status = StIllegal;
            endcase
          end else if (ins_i == InsEbreak) begin
            res_o.trap_cause = TcBreak;
          end else begin
            ill = 1'b1;
          end
        end
        default: ill = 1'b1;
      endcase
      // x0 writes are dropped.
      if (rd == 5'd0) begin
        res_o.wb_valid = 1'b0;
        res_o.wb_value = '0;
      end
      if (ill) begin
        res_o      = '0;
        res_o.status = StIllegal;
        set_pend_o = 1'b0;
        npc        = pc4;
      end else if (res_o.wb_valid) begin
        res_o.wb_index = rd;
      end
      res_o.next_pc = npc;
    end
  end
endmodule

### hdl/riscv_base_integer_execute_core.sv
// Top level of the RV64I execute core.
`timescale 1ns / 1ps
// Usage:
//  Input channel (in_valid_i/in_ready_o) carries an instruction (cmd_i=0) or
//  the data of a pending load (cmd_i=1). Each transfer gives one result on the
//  output channel (out_valid_o/out_ready_i).
//  Stage 1 registers the item while the register file RAMs are read; stage 2
//  executes and writes the output register. Throughput is one item per cycle
//  while the receiver accepts: an item that writes a register or the pc is
//  forwarded into the next read, so back-to-back items run without bubbles.
//  The rate is set by the single execute stage feeding the output register.
//  When the receiver stalls, both stages hold and in_ready_o drops once full.
//  Reset: pc = 0, privilege 3, no load pending, all registers read zero. A
//  start_address write reloads the pc and drops a pending load. Configuration
//  is to be written by the user only while idle; the core does not enforce it.
module riscv_base_integer_execute_core import rbie_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [31:0] instruction_i,
  input  logic [31:0] load_data_i,
  input  logic        load_ok_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [63:0] next_pc_o,
  output logic [1:0]  mem_request_o,
  output logic [63:0] mem_address_o,
  output logic [1:0]  mem_size_o,
  output logic [31:0] mem_write_data_o,
  output logic [2:0]  trap_cause_o,
  output logic        wb_valid_o,
  output logic [4:0]  wb_index_o,
  output logic [63:0] wb_value_o
);
  logic        s1_v_q, ov_q, adv2, adv1;
  logic        cmd_q, ok_q;
  logic [31:0] ins_q, ld_q;
  logic [1:0]  priv_q;
  logic [63:0] pc_q;
  logic        pend_q;
  logic [4:0]  pdest_q;
  logic [2:0]  pkind_q;
  result_t     res, res_q;
  logic        setp, clrp;
  logic [Xlen-1:0] a, b;

  assign adv2       = s1_v_q && (!ov_q || out_ready_i);
  assign in_ready_o = !s1_v_q || adv2;
  assign adv1       = in_valid_i && in_ready_o;

  rbie_regfile u_rf (
    .clk_i, .rst_ni,
    .ra_i(adv1 ? instruction_i[19:15] : ins_q[19:15]),
    .rb_i(adv1 ? instruction_i[24:20] : ins_q[24:20]),
    .we_i(adv2 && res.wb_valid), .wa_i(res.wb_index), .wd_i(res.wb_value),
    .a_o(a), .b_o(b));

  rbie_exec u_ex (
    .cmd_i(cmd_q), .ins_i(ins_q), .ld_data_i(ld_q), .ld_ok_i(ok_q),
    .a_i(a), .b_i(b), .pc_i(pc_q), .priv_i(priv_q), .pend_i(pend_q),
    .pdest_i(pdest_q), .pkind_i(pkind_q), .res_o(res),
    .set_pend_o(setp), .clr_pend_o(clrp));

  // Stage 1 item register and stage 2 output register.
  always_ff @(posedge clk_i) begin
    if (adv1) begin
      cmd_q <= cmd_i;
      ins_q <= instruction_i;
      ld_q  <= load_data_i;
      ok_q  <= load_ok_i;
    end
    if (adv2) res_q <= res;
  end

  // Control and architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      ov_q    <= 1'b0;
      priv_q  <= 2'd3;
      pc_q    <= '0;
      pend_q  <= 1'b0;
      pdest_q <= '0;
      pkind_q <= '0;
    end else begin
      if (adv1)             s1_v_q <= 1'b1;
      else if (adv2)        s1_v_q <= 1'b0;
      if (adv2)             ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
      if (adv2) begin
        pc_q <= res.next_pc;
        if (setp) begin
          pend_q  <= 1'b1;
          pdest_q <= ins_q[11:7];
          pkind_q <= ins_q[14:12];
        end else if (clrp) begin
          pend_q <= 1'b0;
        end
      end
      if (cfg_we_i) begin
        if (cfg_index_i == CfgPriv) begin
          priv_q <= cfg_wdata_i[1:0];
        end else begin
          pc_q    <= cfg_wdata_i;
          pend_q  <= 1'b0;
          pdest_q <= '0;
          pkind_q <= '0;
        end
      end
    end
  end

  assign out_valid_o      = ov_q;
  assign status_o         = res_q.status;
  assign next_pc_o        = res_q.next_pc;
  assign mem_request_o    = res_q.mem_request;
  assign mem_address_o    = res_q.mem_address;
  assign mem_size_o       = res_q.mem_size;
  assign mem_write_data_o = res_q.mem_write_data;
  assign trap_cause_o     = res_q.trap_cause;
  assign wb_valid_o       = res_q.wb_valid;
  assign wb_index_o       = res_q.wb_index;
  assign wb_value_o       = res_q.wb_value;
endmodule

### hdl/rbie_checker.sv
// Port-level checker for the execute core, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rbie_checker import rbie_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  status_o,
  input logic [1:0]  mem_request_o,
  input logic        wb_valid_o,
  input logic [4:0]  wb_index_o,
  input logic [2:0]  trap_cause_o
);
  `CHK_IMPLY(a_x0, clk_i, rst_ni, out_valid_o && wb_valid_o, wb_index_o != 5'd0)
  `CHK_IMPLY(a_ill, clk_i, rst_ni, out_valid_o && status_o != StDone,
    !wb_valid_o && mem_request_o == MrNone && trap_cause_o == TcNone)
  `CHK_IMPLY(a_mem, clk_i, rst_ni, out_valid_o && mem_request_o != MrNone,
    !wb_valid_o && trap_cause_o == TcNone)
  `CHK_NEXT(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
endmodule

bind riscv_base_integer_execute_core rbie_checker u_chk (.*);
